// File: rtl/fbpst_pkg.sv
// Shared types, constants and helpers of the flash block page state tracker.
package fbpst_pkg;

    // Block geometry and stored LPN width
    localparam int MAX_PAGES = 256;
    localparam int MAX_UNITS = 4;
    localparam int LPN_BITS  = 32;

    // Field and counter widths
    localparam int FUNC_W      = 3;
    localparam int ERR_W       = 2;
    localparam int TIME_W      = 48;
    localparam int ERASE_W     = 32;
    localparam int LPN_W       = LPN_BITS;
    localparam int PAGE_W      = $clog2(MAX_PAGES);
    localparam int UNIT_W      = $clog2(MAX_UNITS);
    localparam int PCNT_W      = $clog2(MAX_PAGES + 1);
    localparam int UCNT_W      = $clog2(MAX_PAGES * MAX_UNITS + 1);
    localparam int NU_W        = $clog2(MAX_UNITS + 1);
    localparam int LPN_ADDR_W  = PAGE_W + UNIT_W;
    localparam int LPN_DEPTH   = MAX_PAGES * MAX_UNITS;

    // Configuration port
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_PAGES_W   = 9;
    localparam int CFG_UNITS_W   = 3;
    localparam int CFG_DATA_W    = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNITS = 1'd1;
    localparam logic [CFG_PAGES_W-1:0] PAGES_RESET = 9'd256;
    localparam logic [CFG_UNITS_W-1:0] UNITS_RESET = 3'd1;

    // Function codes
    localparam logic [FUNC_W-1:0] FUNC_READ  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_ERASE = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_INVAL = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 3'd4;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_NONE       = 2'd0;
    localparam logic [ERR_W-1:0] ERR_RANGE      = 2'd1;
    localparam logic [ERR_W-1:0] ERR_NOT_ERASED = 2'd2;
    localparam logic [ERR_W-1:0] ERR_NON_SEQ    = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [PAGE_W-1:0] page_index;
        logic [UNIT_W-1:0] unit_index;
        logic [LPN_W-1:0]  lpn_in;
        logic [TIME_W-1:0] now;
    } req_t;

    typedef struct packed {
        logic                 ok;
        logic [ERR_W-1:0]     error;
        logic [LPN_W-1:0]     lpn_out;
        logic [MAX_UNITS-1:0] valid_map;
        logic [PCNT_W-1:0]    valid_pages;
        logic [UCNT_W-1:0]    valid_units;
        logic [PCNT_W-1:0]    dirty_pages;
        logic [PCNT_W-1:0]    next_write_max;
        logic [PCNT_W-1:0]    next_write_unit;
        logic [ERASE_W-1:0]   erases_done;
        logic [TIME_W-1:0]    last_access_time;
    } rsp_t;

    // Per-page flag word kept in the flag memory
    typedef struct packed {
        logic [MAX_UNITS-1:0] erased;
        logic [MAX_UNITS-1:0] valid;
    } flags_t;

    localparam int FLAGS_W = $bits(flags_t);
    localparam flags_t FLAGS_CLEAN = '{erased: '1, valid: '0};

    // Effective (clamped) block geometry
    typedef struct packed {
        logic [PCNT_W-1:0] pages;
        logic [NU_W-1:0]   units;
    } cfg_eff_t;

    // Number of set bits in a unit mask
    function automatic logic [NU_W-1:0] pop_units(input logic [MAX_UNITS-1:0] v);
        logic [NU_W-1:0] n;
        n = '0;
        for (int i = 0; i < MAX_UNITS; i++) begin
            n = n + NU_W'(v[i]);
        end
        return n;
    endfunction

endpackage

// File: rtl/flash_block_page_state_tracker.sv
// Top level of the flash block page state tracker.
//
// Usage:
//   Requests (read, write, erase, invalidate, status query) arrive on the req
//   channel; one result per request leaves on the rsp channel. A transfer
//   happens on a rising edge where valid is high and stall is low.
//   Configuration (pages in use, units per page) is written through cfg_we,
//   cfg_index and cfg_data while the block is idle; erase the block afterwards.
// Pipeline and throughput:
//   A request is registered at the transfer edge, where the flag and LPN
//   memories are also read; the result register loads as the request leaves
//   the input register. One request per cycle is sustained while rsp_stall
//   does not hold the result; a write forwards its flag and LPN words to the
//   following request, so back-to-back accesses to one page run at full rate.
// Reset:
//   All counters, write pointers and the access time clear. The flag memory
//   needs no clearing pass: a per-page mark, cleared by reset and by erase,
//   makes an unmarked page read as all-erased and not valid.
// Stall:
//   When the result register is held by rsp_stall, one more request is taken
//   into the input register and req_stall rises until the result is taken.
module flash_block_page_state_tracker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  fbpst_pkg::req_t                   req,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output fbpst_pkg::rsp_t                   rsp,
    input  logic                              cfg_we,
    input  logic [fbpst_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fbpst_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import fbpst_pkg::*;

    // Pipeline registers
    req_t s1_reg;
    logic s1_valid_reg;
    rsp_t rsp_reg, rsp_next;
    logic rsp_valid_reg;
    logic s1_fire, out_free, req_xfer;

    // Block state
    logic [MAX_PAGES-1:0] page_written_reg;
    logic [PCNT_W-1:0]    wptr_reg  [MAX_UNITS];
    logic [PCNT_W-1:0]    wptr_next [MAX_UNITS];
    logic [ERASE_W-1:0]   erase_cnt_reg, erase_cnt_next;
    logic [TIME_W-1:0]    last_reg, last_next;
    logic [PCNT_W-1:0]    vpages_reg, vpages_next;
    logic [UCNT_W-1:0]    vunits_reg, vunits_next;
    logic [PCNT_W-1:0]    dpages_reg, dpages_next;

    // Forwarding of the last memory writes
    flags_t                fwd_flags_reg;
    logic [PAGE_W-1:0]     fwd_page_reg;
    logic                  fwd_flags_valid_reg;
    logic [LPN_W-1:0]      fwd_lpn_reg;
    logic [LPN_ADDR_W-1:0] fwd_lpn_addr_reg;
    logic                  fwd_lpn_valid_reg;

    // Memory ports
    logic [PAGE_W-1:0]     flags_raddr;
    logic [LPN_ADDR_W-1:0] lpn_raddr, s1_lpn_addr;
    flags_t                flags_q, flags_wdata;
    logic [LPN_W-1:0]      lpn_q;

    // Operation datapath
    cfg_eff_t             eff;
    flags_t               mem_flags, cur_flags, new_flags;
    logic [LPN_W-1:0]     cur_lpn;
    logic                 inrange, flags_we, lpn_we, erase_op;
    logic [MAX_UNITS-1:0] unit_bit, vmap;
    logic                 ok;
    logic [ERR_W-1:0]     err;
    logic                 vp_old, vp_new, dp_old, dp_new;
    logic [PCNT_W-1:0]    wmax;
    logic [MAX_UNITS-1:0] unit_used;

    fbpst_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .eff       (eff)
    );

    // Handshake control
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign s1_fire   = s1_valid_reg && out_free;
    assign req_stall = s1_valid_reg && !out_free;
    assign req_xfer  = req_valid && !req_stall;

    // Read the incoming page, or re-read the held one while stalled
    assign s1_lpn_addr = {s1_reg.page_index, s1_reg.unit_index};
    assign flags_raddr = req_stall ? s1_reg.page_index : req.page_index;
    assign lpn_raddr   = req_stall ? s1_lpn_addr : {req.page_index, req.unit_index};

    fbpst_ram #(
        .WIDTH (FLAGS_W),
        .DEPTH (MAX_PAGES)
    ) u_flags_ram (
        .clk   (clk),
        .we    (s1_fire && flags_we),
        .waddr (s1_reg.page_index),
        .wdata (flags_wdata),
        .raddr (flags_raddr),
        .rdata (flags_q)
    );

    fbpst_ram #(
        .WIDTH (LPN_W),
        .DEPTH (LPN_DEPTH)
    ) u_lpn_ram (
        .clk   (clk),
        .we    (s1_fire && lpn_we),
        .waddr (s1_lpn_addr),
        .wdata (s1_reg.lpn_in),
        .raddr (lpn_raddr),
        .rdata (lpn_q)
    );

    assign flags_wdata = new_flags;

    // Current flags and LPN of the addressed entry
    always_comb
    begin
        if (fwd_flags_valid_reg && (fwd_page_reg == s1_reg.page_index))
            mem_flags = fwd_flags_reg;
        else
            mem_flags = flags_q;
        cur_flags = page_written_reg[s1_reg.page_index] ? mem_flags : FLAGS_CLEAN;
        if (fwd_lpn_valid_reg && (fwd_lpn_addr_reg == s1_lpn_addr))
            cur_lpn = fwd_lpn_reg;
        else
            cur_lpn = lpn_q;
    end

    // Operation decode and state update
    always_comb
    begin
        inrange = (PCNT_W'(s1_reg.page_index) < eff.pages)
               && (NU_W'(s1_reg.unit_index) < eff.units);
        unit_bit = inrange ? (MAX_UNITS'(1) << s1_reg.unit_index) : '0;
        ok        = 1'b0;
        err       = ERR_NONE;
        new_flags = cur_flags;
        flags_we  = 1'b0;
        lpn_we    = 1'b0;
        erase_op  = 1'b0;
        last_next = last_reg;
        for (int i = 0; i < MAX_UNITS; i++)
        begin
            wptr_next[i] = wptr_reg[i];
        end

        case (s1_reg.func)
            FUNC_ERASE:
            begin
                erase_op = 1'b1;
                for (int i = 0; i < MAX_UNITS; i++)
                begin
                    wptr_next[i] = '0;
                end
            end
            FUNC_READ:
            begin
                if (!inrange)
                    err = ERR_RANGE;
                else if ((cur_flags.valid & unit_bit) != '0)
                begin
                    ok        = 1'b1;
                    last_next = s1_reg.now;
                end
            end
            FUNC_WRITE:
            begin
                if (!inrange)
                    err = ERR_RANGE;
                else if ((cur_flags.erased & unit_bit) == '0)
                    err = ERR_NOT_ERASED;
                else if (PCNT_W'(s1_reg.page_index) < wptr_reg[s1_reg.unit_index])
                    err = ERR_NON_SEQ;
                else
                begin
                    new_flags.erased = cur_flags.erased & ~unit_bit;
                    new_flags.valid  = cur_flags.valid | unit_bit;
                    flags_we  = 1'b1;
                    lpn_we    = 1'b1;
                    ok        = 1'b1;
                    last_next = s1_reg.now;
                    wptr_next[s1_reg.unit_index] = PCNT_W'(s1_reg.page_index) + PCNT_W'(1);
                end
            end
            FUNC_INVAL:
            begin
                if (!inrange)
                    err = ERR_RANGE;
                else
                begin
                    new_flags.valid = cur_flags.valid & ~unit_bit;
                    flags_we = 1'b1;
                end
            end
            FUNC_QUERY:
            begin
                if (!inrange)
                    err = ERR_RANGE;
                else
                    ok = (cur_flags.valid != '0);
            end
            default: ;
        endcase

        // Running counters: take the page's old share out, put the new one in
        vp_old = (cur_flags.valid != '0);
        vp_new = (new_flags.valid != '0);
        dp_old = ((~(cur_flags.valid | cur_flags.erased)) != '0);
        dp_new = ((~(new_flags.valid | new_flags.erased)) != '0);
        if (erase_op)
        begin
            vpages_next = '0;
            vunits_next = '0;
            dpages_next = '0;
        end
        else
        begin
            vpages_next = vpages_reg - PCNT_W'(vp_old) + PCNT_W'(vp_new);
            dpages_next = dpages_reg - PCNT_W'(dp_old) + PCNT_W'(dp_new);
            vunits_next = vunits_reg - UCNT_W'(pop_units(cur_flags.valid))
                        + UCNT_W'(pop_units(new_flags.valid));
        end

        // Saturating erase count
        if (erase_op && (erase_cnt_reg != '1))
            erase_cnt_next = erase_cnt_reg + ERASE_W'(1);
        else
            erase_cnt_next = erase_cnt_reg;

        // Largest write pointer over the units in use
        wmax = '0;
        for (int i = 0; i < MAX_UNITS; i++)
        begin
            unit_used[i] = (NU_W'(i) < eff.units);
            if (unit_used[i] && (wptr_next[i] > wmax))
                wmax = wptr_next[i];
        end
    end

    // Result assembly
    always_comb
    begin
        vmap = (inrange && !erase_op) ? new_flags.valid : '0;
        rsp_next.ok    = ok;
        rsp_next.error = err;
        if (lpn_we)
            rsp_next.lpn_out = s1_reg.lpn_in;
        else if ((vmap & unit_bit) != '0)
            rsp_next.lpn_out = cur_lpn;
        else
            rsp_next.lpn_out = '0;
        rsp_next.valid_map        = vmap;
        rsp_next.valid_pages      = vpages_next;
        rsp_next.valid_units      = vunits_next;
        rsp_next.dirty_pages      = dpages_next;
        rsp_next.next_write_max   = wmax;
        rsp_next.next_write_unit  = inrange ? wptr_next[s1_reg.unit_index] : '0;
        rsp_next.erases_done      = erase_cnt_next;
        rsp_next.last_access_time = last_next;
    end

    // Pipeline control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg        <= 1'b0;
            rsp_valid_reg       <= 1'b0;
            fwd_flags_valid_reg <= 1'b0;
            fwd_lpn_valid_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg        <= req_xfer || (s1_valid_reg && !s1_fire);
            rsp_valid_reg       <= s1_fire || (rsp_valid_reg && rsp_stall);
            fwd_flags_valid_reg <= s1_fire && flags_we;
            fwd_lpn_valid_reg   <= s1_fire && lpn_we;
        end
    end

    // Block state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_written_reg <= '0;
            erase_cnt_reg    <= '0;
            last_reg         <= '0;
            vpages_reg       <= '0;
            vunits_reg       <= '0;
            dpages_reg       <= '0;
            for (int i = 0; i < MAX_UNITS; i++)
            begin
                wptr_reg[i] <= '0;
            end
        end
        else if (s1_fire)
        begin
            if (erase_op)
                page_written_reg <= '0;
            else if (flags_we)
                page_written_reg[s1_reg.page_index] <= 1'b1;
            erase_cnt_reg <= erase_cnt_next;
            last_reg      <= last_next;
            vpages_reg    <= vpages_next;
            vunits_reg    <= vunits_next;
            dpages_reg    <= dpages_next;
            for (int i = 0; i < MAX_UNITS; i++)
            begin
                wptr_reg[i] <= wptr_next[i];
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req_xfer)
            s1_reg <= req;
        if (s1_fire)
            rsp_reg <= rsp_next;
        if (s1_fire && flags_we)
        begin
            fwd_flags_reg <= new_flags;
            fwd_page_reg  <= s1_reg.page_index;
        end
        if (s1_fire && lpn_we)
        begin
            fwd_lpn_reg      <= s1_reg.lpn_in;
            fwd_lpn_addr_reg <= s1_lpn_addr;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef NO_ASSERTIONS
    // Unit count never exceeds the physical unit total
    a_units_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vunits_reg <= UCNT_W'(MAX_PAGES * MAX_UNITS))
        else $error("valid unit count above block size");

    // A page counts as valid only if one of its units is valid
    a_pages_le_units: assert property (@(posedge clk) disable iff (!rst_n)
        UCNT_W'(vpages_reg) <= vunits_reg)
        else $error("valid page count above valid unit count");

    // Erase clears the page marks, the valid unit count and the dirty page count
    a_erase_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && (s1_reg.func == FUNC_ERASE)) |=>
        (page_written_reg == '0) && (vunits_reg == '0) && (dpages_reg == '0))
        else $error("erase left state behind");

    // Input stalls only while a request is held behind a blocked result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (s1_valid_reg && rsp_valid_reg && rsp_stall))
        else $error("input stalled without a blocked result");

    // Forwarded flags live for exactly the cycle after their write
    a_fwd_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_flags_valid_reg |-> $past(s1_fire))
        else $error("stale flag forwarding");
`endif

endmodule

// File: rtl/fbpst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fbpst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read (read returns old data on a collision)
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/fbpst_cfg.sv
// Configuration registers and clamped block geometry.
module fbpst_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [fbpst_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fbpst_pkg::CFG_DATA_W-1:0]   cfg_data,
    output fbpst_pkg::cfg_eff_t                eff
);
    import fbpst_pkg::*;

    logic [CFG_PAGES_W-1:0] pages_reg, pages_next;
    logic [CFG_UNITS_W-1:0] units_reg, units_next;

    // Register write decode
    always_comb
    begin
        pages_next = pages_reg;
        units_next = units_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_PAGES: pages_next = cfg_data[CFG_PAGES_W-1:0];
                CFG_UNITS: units_next = cfg_data[CFG_UNITS_W-1:0];
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pages_reg <= PAGES_RESET;
            units_reg <= UNITS_RESET;
        end
        else
        begin
            pages_reg <= pages_next;
            units_reg <= units_next;
        end
    end

    // Zero counts as one, anything above the maximum as the maximum
    always_comb
    begin
        if (pages_reg == '0)
            eff.pages = PCNT_W'(1);
        else if (pages_reg > CFG_PAGES_W'(MAX_PAGES))
            eff.pages = PCNT_W'(MAX_PAGES);
        else
            eff.pages = PCNT_W'(pages_reg);

        if (units_reg == '0)
            eff.units = NU_W'(1);
        else if (units_reg > CFG_UNITS_W'(MAX_UNITS))
            eff.units = NU_W'(MAX_UNITS);
        else
            eff.units = NU_W'(units_reg);
    end

endmodule

// File: tb/sv/flash_block_page_state_tracker_tb.sv
// Testbench for the flash block page state tracker: directed table, then random traffic.
`timescale 1ns / 1ps

module flash_block_page_state_tracker_tb;
    import fbpst_pkg::*;

    // Function codes that the block treats as no operation
    localparam logic [FUNC_W-1:0] FUNC_NOP_LO = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_NOP_HI = 3'd7;
    localparam int PHASE_ITEMS = 220;

    typedef enum logic {ROW_OP, ROW_GEOM} row_kind_t;

    // One row of the directed table
    typedef struct {
        row_kind_t              kind;
        req_t                   item;
        logic [CFG_DATA_W-1:0]  pages;
        logic [CFG_DATA_W-1:0]  units;
        bit                     typed;
        logic                   ok;
        logic [ERR_W-1:0]       err;
    } dir_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   req_valid;
    logic                   req_stall;
    req_t                   req;
    logic                   rsp_valid;
    logic                   rsp_stall = 1'b0;
    rsp_t                   rsp;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Typed expectation traveling with a directed transfer
    logic                   typed_chk;
    logic                   typed_ok;
    logic [ERR_W-1:0]       typed_err;

    // Shadow copy of the block state
    logic [MAX_UNITS-1:0]   blk_valid [MAX_PAGES];
    logic [MAX_UNITS-1:0]   blk_erased [MAX_PAGES];
    logic [LPN_W-1:0]       blk_lpn [LPN_DEPTH];
    logic [PCNT_W-1:0]      blk_wptr [MAX_UNITS];
    logic [ERASE_W-1:0]     blk_erases;
    logic [TIME_W-1:0]      blk_last;
    int unsigned            cnt_vpages;
    int unsigned            cnt_vunits;
    int unsigned            cnt_dpages;
    logic [CFG_PAGES_W-1:0] geo_pages;
    logic [CFG_UNITS_W-1:0] geo_units;

    rsp_t                   page_status_q [$];
    dir_row_t               dir_rows [$];
    int                     mismatch_count;
    int                     burst_left;
    bit                     sender_idles;
    int                     stall_mode;
    int                     stall_left;

    int unsigned geo_pages_list [6] = '{256, 1, 0, 511, 2, 300};
    int unsigned geo_units_list [6] = '{4, 1, 0, 7, 3, 2};

    flash_block_page_state_tracker i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

    // Clamped geometry
    function automatic int unsigned pages_used();
        if (geo_pages == 0) return 1;
        if (geo_pages > MAX_PAGES) return MAX_PAGES;
        return geo_pages;
    endfunction

    function automatic int unsigned units_used();
        if (geo_units == 0) return 1;
        if (geo_units > MAX_UNITS) return MAX_UNITS;
        return geo_units;
    endfunction

    function automatic void erase_block();
        for (int p = 0; p < MAX_PAGES; p++)
        begin
            blk_valid[p]  = '0;
            blk_erased[p] = '1;
        end
        for (int u = 0; u < MAX_UNITS; u++)
            blk_wptr[u] = '0;
        cnt_vpages = 0;
        cnt_vunits = 0;
        cnt_dpages = 0;
    endfunction

    // Remove a page's share from the running totals, or add it back
    function automatic void tally_page(int p, bit add);
        logic [MAX_UNITS-1:0] v;
        logic [MAX_UNITS-1:0] d;
        v = blk_valid[p];
        d = ~(blk_valid[p] | blk_erased[p]);
        if (add)
        begin
            cnt_vpages += (v != 0);
            cnt_dpages += (d != 0);
            cnt_vunits += $countones(v);
        end
        else
        begin
            cnt_vpages -= (v != 0);
            cnt_dpages -= (d != 0);
            cnt_vunits -= $countones(v);
        end
    endfunction

    // Apply one operation to the shadow state and return the status it gives
    function automatic rsp_t apply_block_op(req_t r);
        rsp_t                 o;
        int unsigned          np;
        int unsigned          nu;
        int                   p;
        int                   u;
        bit                   inr;
        logic [MAX_UNITS-1:0] bitm;
        o   = '0;
        np  = pages_used();
        nu  = units_used();
        p   = r.page_index;
        u   = r.unit_index;
        inr = (p < np) && (u < nu);
        bitm = inr ? (MAX_UNITS'(1) << u) : '0;
        o.error = ERR_NONE;

        if (r.func == FUNC_ERASE)
        begin
            erase_block();
            if (blk_erases != '1)
                blk_erases++;
        end
        else if (r.func <= FUNC_QUERY)
        begin
            if (!inr)
                o.error = ERR_RANGE;
            else if (r.func == FUNC_READ)
            begin
                if ((blk_valid[p] & bitm) != 0)
                begin
                    o.ok     = 1'b1;
                    blk_last = r.now;
                end
            end
            else if (r.func == FUNC_WRITE)
            begin
                if ((blk_erased[p] & bitm) == 0)
                    o.error = ERR_NOT_ERASED;
                else if (p < blk_wptr[u])
                    o.error = ERR_NON_SEQ;
                else
                begin
                    tally_page(p, 1'b0);
                    blk_erased[p] &= ~bitm;
                    blk_valid[p]  |= bitm;
                    tally_page(p, 1'b1);
                    blk_lpn[p * MAX_UNITS + u] = r.lpn_in;
                    blk_wptr[u] = PCNT_W'(p + 1);
                    blk_last = r.now;
                    o.ok = 1'b1;
                end
            end
            else if (r.func == FUNC_INVAL)
            begin
                tally_page(p, 1'b0);
                blk_valid[p] &= ~bitm;
                tally_page(p, 1'b1);
            end
            else
                o.ok = (blk_valid[p] != 0);
        end

        // Addressed and block-wide outputs
        if (inr)
        begin
            o.valid_map = blk_valid[p];
            if ((blk_valid[p] & bitm) != 0)
                o.lpn_out = blk_lpn[p * MAX_UNITS + u];
            o.next_write_unit = blk_wptr[u];
        end
        for (int i = 0; i < nu; i++)
            if (blk_wptr[i] > o.next_write_max)
                o.next_write_max = blk_wptr[i];
        o.valid_pages      = PCNT_W'(cnt_vpages);
        o.valid_units      = UCNT_W'(cnt_vunits);
        o.dirty_pages      = PCNT_W'(cnt_dpages);
        o.erases_done      = blk_erases;
        o.last_access_time = blk_last;
        return o;
    endfunction

    task automatic flag_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    task automatic check_status(input rsp_t got, input rsp_t want);
        if (got.ok !== want.ok)
            flag_mismatch("ok", got.ok, want.ok);
        if (got.error !== want.error)
            flag_mismatch("error", got.error, want.error);
        if (got.lpn_out !== want.lpn_out)
            flag_mismatch("lpn_out", got.lpn_out, want.lpn_out);
        if (got.valid_map !== want.valid_map)
            flag_mismatch("valid_map", got.valid_map, want.valid_map);
        if (got.valid_pages !== want.valid_pages)
            flag_mismatch("valid_pages", got.valid_pages, want.valid_pages);
        if (got.valid_units !== want.valid_units)
            flag_mismatch("valid_units", got.valid_units, want.valid_units);
        if (got.dirty_pages !== want.dirty_pages)
            flag_mismatch("dirty_pages", got.dirty_pages, want.dirty_pages);
        if (got.next_write_max !== want.next_write_max)
            flag_mismatch("next_write_max", got.next_write_max, want.next_write_max);
        if (got.next_write_unit !== want.next_write_unit)
            flag_mismatch("next_write_unit", got.next_write_unit, want.next_write_unit);
        if (got.erases_done !== want.erases_done)
            flag_mismatch("erases_done", got.erases_done, want.erases_done);
        if (got.last_access_time !== want.last_access_time)
            flag_mismatch("last_access_time", got.last_access_time, want.last_access_time);
    endtask

    // Transfer monitor: config writes, request prediction, result checking
    always @(posedge clk)
    begin : status_monitor
        rsp_t want;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_PAGES)
                    geo_pages = cfg_data[CFG_PAGES_W-1:0];
                else if (cfg_index == CFG_UNITS)
                    geo_units = cfg_data[CFG_UNITS_W-1:0];
            end
            // Check before queuing, so a stray result cannot match a fresh request
            if (rsp_valid && !rsp_stall)
            begin
                if (page_status_q.size() == 0)
                    flag_mismatch("result with nothing pending", 64'(rsp), 0);
                else
                    check_status(rsp, page_status_q.pop_front());
            end
            if (req_valid && !req_stall)
            begin
                want = apply_block_op(req);
                if (typed_chk)
                begin
                    want.ok    = typed_ok;
                    want.error = typed_err;
                end
                page_status_q.push_back(want);
            end
        end
    end

    // Result side stall pattern: modes from never to mostly stalled
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
        end
        stall_left--;
        case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 1) == 0);
            default: rsp_stall <= ($urandom_range(0, 9) < 8);
        endcase
    end

    // Send one request, in bursts with random gaps between them while sender_idles is set
    task automatic issue(input req_t item, input bit chk, input logic ok,
                         input logic [ERR_W-1:0] err);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            if (sender_idles)
            begin
                req_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        burst_left--;
        req       <= item;
        typed_chk <= chk;
        typed_ok  <= ok;
        typed_err <= err;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    // Hold off the sender until every pending result has been taken
    task automatic wait_all_results();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (page_status_q.size() != 0);
    endtask

    // Write both geometry registers; upper bits of the unit write carry noise
    task automatic set_geometry(input logic [CFG_DATA_W-1:0] pages,
                                input logic [CFG_DATA_W-1:0] units);
        logic [31:0] junk;
        junk = $urandom;
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PAGES;
        cfg_data  <= pages;
        @(posedge clk);
        cfg_index <= CFG_UNITS;
        cfg_data  <= {junk[CFG_DATA_W-CFG_UNITS_W-1:0], units[CFG_UNITS_W-1:0]};
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic dir_row_t op_row(logic [FUNC_W-1:0] func, int page, int unit,
                                        logic [LPN_W-1:0] lpn, logic [TIME_W-1:0] stamp,
                                        bit typed, logic ok, logic [ERR_W-1:0] err);
        dir_row_t r;
        r.kind  = ROW_OP;
        r.item  = '{func: func, page_index: PAGE_W'(page), unit_index: UNIT_W'(unit),
                    lpn_in: lpn, now: stamp};
        r.pages = '0;
        r.units = '0;
        r.typed = typed;
        r.ok    = ok;
        r.err   = err;
        return r;
    endfunction

    function automatic dir_row_t geom_row(logic [CFG_DATA_W-1:0] pages,
                                          logic [CFG_DATA_W-1:0] units);
        dir_row_t r;
        r       = op_row(FUNC_QUERY, 0, 0, '0, '0, 1'b0, 1'b0, ERR_NONE);
        r.kind  = ROW_GEOM;
        r.pages = pages;
        r.units = units;
        return r;
    endfunction

    // Random request, mostly well-formed sequential writes and accesses to written pages
    function automatic req_t next_random_item();
        req_t        r;
        int unsigned sel;
        int unsigned np;
        int unsigned nu;
        int unsigned u;
        int unsigned top;
        np  = pages_used();
        nu  = units_used();
        sel = $urandom_range(0, 99);
        u   = $urandom_range(0, nu - 1);
        top = blk_wptr[u];
        r.lpn_in     = $urandom;
        r.now        = TIME_W'({$urandom, $urandom});
        r.unit_index = UNIT_W'(u);
        r.page_index = PAGE_W'((top == 0) ? 0 : $urandom_range(0, top - 1));
        if (sel < 3)
        begin
            r.func       = FUNC_ERASE;
            r.page_index = PAGE_W'($urandom_range(0, MAX_PAGES - 1));
            r.unit_index = UNIT_W'($urandom_range(0, MAX_UNITS - 1));
        end
        else if (sel < 45)
        begin
            r.func = FUNC_WRITE;
            r.page_index = PAGE_W'(top + (($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 3)));
        end
        else if (sel < 65)
            r.func = FUNC_READ;
        else if (sel < 75)
            r.func = FUNC_INVAL;
        else if (sel < 85)
        begin
            r.func       = FUNC_QUERY;
            r.page_index = PAGE_W'($urandom_range(0, np - 1));
        end
        else
        begin
            // Noise: any address, any code
            r.func = (sel < 93) ? FUNC_W'($urandom_range(FUNC_READ, FUNC_QUERY))
                                : FUNC_W'($urandom_range(FUNC_NOP_LO, FUNC_NOP_HI));
            r.page_index = PAGE_W'($urandom_range(0, MAX_PAGES - 1));
            r.unit_index = UNIT_W'($urandom_range(0, MAX_UNITS - 1));
        end
        return r;
    endfunction

    initial
    begin
        req_t     item;
        dir_row_t row;
        int       counted;

        rst_n          = 1'b0;
        req_valid      = 1'b0;
        req            = '0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_PAGES;
        cfg_data       = '0;
        typed_chk      = 1'b0;
        typed_ok       = 1'b0;
        typed_err      = ERR_NONE;
        mismatch_count = 0;
        burst_left     = 0;
        sender_idles   = 1'b1;
        stall_mode     = 0;
        stall_left     = 0;
        geo_pages      = PAGES_RESET;
        geo_units      = UNITS_RESET;
        blk_erases     = '0;
        blk_last       = '0;
        erase_block();
        for (int i = 0; i < LPN_DEPTH; i++)
            blk_lpn[i] = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, starting from the reset geometry (256 pages, one unit)
        dir_rows.push_back(op_row(FUNC_QUERY, 0, 0, '0, '0, 1, 0, ERR_NONE));
        dir_rows.push_back(op_row(FUNC_READ, 0, 0, '0, '0, 1, 0, ERR_NONE));
        dir_rows.push_back(op_row(FUNC_READ, 0, 1, '0, '0, 1, 0, ERR_RANGE));
        dir_rows.push_back(op_row(FUNC_WRITE, 0, 0, '1, '1, 1, 1, ERR_NONE));
        dir_rows.push_back(op_row(FUNC_READ, 0, 0, '0, '0, 1, 1, ERR_NONE));
        dir_rows.push_back(op_row(FUNC_WRITE, 0, 0, 32'h1, '0, 1, 0, ERR_NOT_ERASED));
        dir_rows.push_back(op_row(FUNC_WRITE, 255, 0, '0, 48'h8000_0000_0001, 1, 1, ERR_NONE));
        dir_rows.push_back(op_row(FUNC_WRITE, 10, 0, 32'h77, '0, 1, 0, ERR_NON_SEQ));
        dir_rows.push_back(op_row(FUNC_QUERY, 255, 0, '0, '0, 1, 1, ERR_NONE));
        dir_rows.push_back(op_row(FUNC_INVAL, 255, 0, '0, '0, 1, 0, ERR_NONE));
        // invalidate of a unit that is no longer valid
        dir_rows.push_back(op_row(FUNC_INVAL, 255, 0, '0, '0, 1, 0, ERR_NONE));
        dir_rows.push_back(op_row(FUNC_READ, 255, 0, '0, '1, 1, 0, ERR_NONE));
        dir_rows.push_back(op_row(FUNC_NOP_LO, 0, 0, '1, '1, 1, 0, ERR_NONE));
        dir_rows.push_back(op_row(FUNC_NOP_HI, 255, 3, '1, '1, 1, 0, ERR_NONE));
        // erase with indices out of range
        dir_rows.push_back(op_row(FUNC_ERASE, 255, 3, '1, '1, 1, 0, ERR_NONE));
        dir_rows.push_back(op_row(FUNC_WRITE, 0, 0, 32'h1234, 48'h55, 1, 1, ERR_NONE));
        dir_rows.push_back(op_row(FUNC_WRITE, 3, 3, 32'h1, '0, 1, 0, ERR_RANGE));
        // zero pages counts as one, units above the maximum clamp to four
        dir_rows.push_back(geom_row(9'd0, 9'h1FF));
        dir_rows.push_back(op_row(FUNC_ERASE, 0, 0, '0, '0, 1, 0, ERR_NONE));
        dir_rows.push_back(op_row(FUNC_WRITE, 1, 0, 32'h9, '0, 1, 0, ERR_RANGE));
        dir_rows.push_back(op_row(FUNC_WRITE, 0, 3, 32'hA5A5_5A5A, 48'h1, 1, 1, ERR_NONE));
        dir_rows.push_back(op_row(FUNC_READ, 0, 3, '0, 48'h2, 0, 0, ERR_NONE));
        dir_rows.push_back(op_row(FUNC_QUERY, 0, 2, '0, '0, 1, 1, ERR_NONE));
        dir_rows.push_back(op_row(FUNC_WRITE, 0, 3, 32'h3, '0, 1, 0, ERR_NOT_ERASED));
        // pages above the maximum, zero units; no erase after this change
        dir_rows.push_back(geom_row(9'd511, 9'd0));
        dir_rows.push_back(op_row(FUNC_READ, 0, 3, '0, '0, 1, 0, ERR_RANGE));
        dir_rows.push_back(op_row(FUNC_QUERY, 0, 0, '0, '0, 1, 1, ERR_NONE));
        dir_rows.push_back(op_row(FUNC_WRITE, 1, 0, 32'hCAFE, 48'h3, 0, 0, ERR_NONE));

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.kind == ROW_GEOM)
            begin
                wait_all_results();
                set_geometry(row.pages, row.units);
            end
            else
                issue(row.item, row.typed, row.ok, row.err);
        end

        // Random phases, each under its own geometry
        for (int phase = 0; phase < 8; phase++)
        begin
            wait_all_results();
            if (phase < 6)
                set_geometry(CFG_DATA_W'(geo_pages_list[phase]),
                             CFG_DATA_W'(geo_units_list[phase]));
            else
                set_geometry(CFG_DATA_W'($urandom_range(1, MAX_PAGES)),
                             CFG_DATA_W'($urandom_range(1, MAX_UNITS)));
            sender_idles = (phase % 3) != 2;
            // one phase keeps the old contents across the geometry change
            if (phase != 4)
            begin
                item      = next_random_item();
                item.func = FUNC_ERASE;
                issue(item, 1'b0, 1'b0, ERR_NONE);
            end
            counted = 0;
            while (counted < PHASE_ITEMS)
            begin
                if (phase == 2 && counted == PHASE_ITEMS / 2)
                    wait_all_results();
                item = next_random_item();
                if (item.func <= FUNC_QUERY)
                    counted++;
                issue(item, 1'b0, 1'b0, ERR_NONE);
            end
        end

        wait_all_results();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: filelist.f
rtl/fbpst_pkg.sv
rtl/fbpst_ram.sv
rtl/fbpst_cfg.sv
rtl/flash_block_page_state_tracker.sv
tb/sv/flash_block_page_state_tracker_tb.sv
